>>> rtl/jsf32_prng_bounded_draw_unit_macros.svh
// assertion macros shared by the bounded draw unit and its remainder unit
`ifndef JSF32_PRNG_BOUNDED_DRAW_UNIT_MACROS_SVH
`define JSF32_PRNG_BOUNDED_DRAW_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define JSFBD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define JSFBD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jsfbd_pkg.sv
// shared types, constants and the generator round function
package jsfbd_pkg;

  // seeding constant loaded into word a
  localparam logic [31:0] SEED_CONST = 32'hf1ea5eed;

  // rotate amounts of the round
  localparam int unsigned ROT_B = 27;
  localparam int unsigned ROT_C = 17;

  // request operation codes
  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_DRAW32 = 2'd1;
  localparam logic [1:0] OP_DRAW64 = 2'd2;
  localparam logic [1:0] OP_LUCKY  = 2'd3;

  // remainder unit step counts
  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_WIDE_STEPS  = 7'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_SHORT_STEPS = 7'd32;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } jsf_state_t;

  // control from the sequencer to the remainder unit
  typedef struct packed {
    logic start;
    logic wide;
  } div_ctrl_t;

  // status from the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // one generator round; the output word is the new d
  function automatic jsf_state_t jsf_round(input jsf_state_t s);
    jsf_state_t  n;
    logic [31:0] e;
    e   = s.a - ((s.b << ROT_B) | (s.b >> (32 - ROT_B)));
    n.a = s.b ^ ((s.c << ROT_C) | (s.c >> (32 - ROT_C)));
    n.b = s.c + s.d;
    n.c = s.d + e;
    n.d = e + n.a;
    return n;
  endfunction

endpackage

>>> rtl/jsfbd_divider.sv
// bit-serial restoring remainder unit, 32 or 64 steps per request
`include "jsf32_prng_bounded_draw_unit_macros.svh"

module jsfbd_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  jsfbd_pkg::div_ctrl_t    ctrl,
  input  logic [63:0]             dividend,
  input  logic [63:0]             divisor,
  output jsfbd_pkg::div_stat_t    stat,
  output logic [63:0]             remainder
);

  logic [63:0]                     rem;
  logic [63:0]                     quo;
  logic [63:0]                     dsr;
  logic [jsfbd_pkg::DIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic                            done;

  logic [64:0] trial;
  logic [65:0] diff;
  logic [63:0] rem_next;

  // one shift and trial subtract per cycle while busy
  always_comb begin
    trial    = {rem, quo[63]};
    diff     = {1'b0, trial} - {2'b00, dsr};
    rem_next = diff[65] ? trial[63:0] : diff[63:0];
  end

  // step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !ctrl.start && busy && (cnt == jsfbd_pkg::DIV_CNT_W'(1));
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.wide ? jsfbd_pkg::DIV_WIDE_STEPS : jsfbd_pkg::DIV_SHORT_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == jsfbd_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // operand registers; a short request uses only the low dividend word
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= ctrl.wide ? dividend : {dividend[31:0], 32'h0};
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[62:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

  `JSFBD_ASSERT_IMP(a_div_rem_below, clk, rst, done, rem < dsr, "remainder not below divisor")
  `JSFBD_ASSERT_IMP(a_div_no_restart, clk, rst, ctrl.start, !busy, "start while busy")
  `JSFBD_ASSERT_IMP(a_div_done_end, clk, rst, $fell(busy), done, "busy ended without done")

endmodule

>>> rtl/jsf32_prng_bounded_draw_unit.sv
// bounded draws from a four-word jsf32 generator under a small sequencer
//
// Requests arrive on the s_axis group: tuser carries the operation (reseed,
// unsigned 32-bit draw, signed 64-bit draw, lucky test), tdata carries seed,
// range_min and range_max. Each request gives exactly one response on the
// m_axis group: tdata is the value, tuser the error flag.
// One request is worked at a time; s_axis_tready is high only while idle.
// Steps from accept to m_axis_tvalid, worked by the sequencer and the
// bit-serial remainder unit (one quotient bit per cycle):
//   reseed: WARMUP_ROUNDS rounds; range error: no round, state untouched
//   unsigned draw and lucky test: one round and a short reduction, the
//     reduction skipped for an unsigned draw over the full 32-bit range
//   signed draw: 64-step threshold, two rounds per join until one is kept,
//     64-step final reduction; both skipped with a full 64-bit range
// The response is held in registers until m_axis_tready; a stalled receiver
// stalls the block. Reset loads the seeding constant into word a and clears
// words b, c and d, then the block waits idle.
`include "jsf32_prng_bounded_draw_unit_macros.svh"

module jsf32_prng_bounded_draw_unit #(
  parameter int unsigned WARMUP_ROUNDS = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,   // seed[31:0], range_min[95:32], range_max[159:96]
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // value[63:0]
  output logic [0:0]   m_axis_tuser    // error[0]
);

  localparam int unsigned CNT_W = $clog2(WARMUP_ROUNDS + 2);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_WARM  = 4'd2;
  localparam logic [3:0] S_DRAW  = 4'd3;
  localparam logic [3:0] S_THRS  = 4'd4;
  localparam logic [3:0] S_THR   = 4'd5;
  localparam logic [3:0] S_HI    = 4'd6;
  localparam logic [3:0] S_LO    = 4'd7;
  localparam logic [3:0] S_MOD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state;
  logic [31:0]      word_a;
  logic [31:0]      word_b;
  logic [31:0]      word_c;
  logic [31:0]      word_d;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       op_q;
  logic [31:0]      seed_q;
  logic [63:0]      mn_q;
  logic [63:0]      mx_q;
  logic [63:0]      span_q;
  logic [63:0]      thr_q;
  logic [31:0]      hi_q;
  logic [63:0]      value_q;
  logic             error_q;

  jsfbd_pkg::jsf_state_t round;
  logic [63:0]           join_v;
  logic                  full32;

  jsfbd_pkg::div_ctrl_t div_ctrl;
  jsfbd_pkg::div_stat_t div_stat;
  logic [63:0]          div_dividend;
  logic [63:0]          div_rem;

  // one generator round on the current state
  always_comb begin
    round  = jsfbd_pkg::jsf_round({word_a, word_b, word_c, word_d});
    join_v = {hi_q, round.d};
    full32 = (op_q == jsfbd_pkg::OP_DRAW32) && (span_q[31:0] == 32'h0);
  end

  // remainder unit launch
  always_comb begin
    div_ctrl.wide  = (op_q == jsfbd_pkg::OP_DRAW64);
    div_ctrl.start = 1'b0;
    div_dividend   = join_v;
    unique case (state)
      S_DRAW: begin
        div_ctrl.start = !full32;
        div_dividend   = {32'h0, round.d};
      end
      S_THRS: begin
        div_ctrl.start = (span_q != 64'h0);
        div_dividend   = 64'h0 - span_q;
      end
      S_LO: begin
        div_ctrl.start = (join_v >= thr_q) && (span_q != 64'h0);
        div_dividend   = join_v;
      end
      default: begin
        div_ctrl.start = 1'b0;
        div_dividend   = join_v;
      end
    endcase
  end

  jsfbd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (span_q),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      word_a <= jsfbd_pkg::SEED_CONST;
      word_b <= 32'h0;
      word_c <= 32'h0;
      word_d <= 32'h0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q   <= s_axis_tuser;
            seed_q <= s_axis_tdata[31:0];
            mn_q   <= s_axis_tdata[95:32];
            mx_q   <= s_axis_tdata[159:96];
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          value_q <= 64'h0;
          case (op_q)
            jsfbd_pkg::OP_RESEED: begin
              error_q <= 1'b0;
              word_a  <= jsfbd_pkg::SEED_CONST;
              word_b  <= seed_q;
              word_c  <= seed_q;
              word_d  <= seed_q;
              cnt     <= CNT_W'(WARMUP_ROUNDS);
              state   <= (WARMUP_ROUNDS == 0) ? S_OUT : S_WARM;
            end
            jsfbd_pkg::OP_DRAW32: begin
              if (mx_q[31:0] < mn_q[31:0]) begin
                error_q <= 1'b1;
                state   <= S_OUT;
              end else begin
                error_q <= 1'b0;
                span_q  <= {32'h0, mx_q[31:0] - mn_q[31:0] + 32'h1};
                state   <= S_DRAW;
              end
            end
            jsfbd_pkg::OP_DRAW64: begin
              if ($signed(mx_q) < $signed(mn_q)) begin
                error_q <= 1'b1;
                state   <= S_OUT;
              end else begin
                error_q <= 1'b0;
                span_q  <= mx_q - mn_q + 64'h1;
                state   <= S_THRS;
              end
            end
            default: begin
              if (mx_q[31:0] == 32'h0) begin
                error_q <= 1'b1;
                state   <= S_OUT;
              end else begin
                error_q <= 1'b0;
                span_q  <= {32'h0, mx_q[31:0]};
                state   <= S_DRAW;
              end
            end
          endcase
        end
        S_WARM: begin
          {word_a, word_b, word_c, word_d} <= round;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_OUT;
          end
        end
        S_DRAW: begin
          {word_a, word_b, word_c, word_d} <= round;
          if (full32) begin
            value_q <= {32'h0, mn_q[31:0] + round.d};
            state   <= S_OUT;
          end else begin
            state <= S_MOD;
          end
        end
        S_THRS: begin
          if (span_q == 64'h0) begin
            thr_q <= 64'h0;
            state <= S_HI;
          end else begin
            state <= S_THR;
          end
        end
        S_THR: begin
          if (div_stat.done) begin
            thr_q <= div_rem;
            state <= S_HI;
          end
        end
        S_HI: begin
          {word_a, word_b, word_c, word_d} <= round;
          hi_q  <= round.d;
          state <= S_LO;
        end
        S_LO: begin
          {word_a, word_b, word_c, word_d} <= round;
          if (join_v < thr_q) begin
            state <= S_HI;
          end else if (span_q == 64'h0) begin
            value_q <= mn_q + join_v;
            state   <= S_OUT;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_stat.done) begin
            case (op_q)
              jsfbd_pkg::OP_DRAW32: value_q <= {32'h0, mn_q[31:0] + div_rem[31:0]};
              jsfbd_pkg::OP_DRAW64: value_q <= mn_q + div_rem;
              default:              value_q <= {63'h0, div_rem == 64'h0};
            endcase
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // handshake outputs
  assign s_axis_tready   = (state == S_IDLE);
  assign m_axis_tvalid   = (state == S_OUT);
  assign m_axis_tdata    = value_q;
  assign m_axis_tuser[0] = error_q;

  `JSFBD_ASSERT_IMP(a_one_in_flight, clk, rst, s_axis_tready, !m_axis_tvalid, "ready while response pending")
  `JSFBD_ASSERT_IMP(a_error_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'h0, "error with nonzero value")
  `JSFBD_ASSERT_IMP(a_div_running, clk, rst, (state == S_THR) || (state == S_MOD), div_stat.busy || div_stat.done, "waiting on idle remainder unit")

endmodule

>>> tb/tb_jsf32_prng_bounded_draw_unit.sv
// self-checking testbench for the jsf32 bounded draw unit: directed and random requests
module tb_jsf32_prng_bounded_draw_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WARMUP_ROUNDS = 20;
  localparam int unsigned N_DIRECTED    = 25;
  localparam int unsigned N_RANDOM      = 750;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam logic [63:0] INT64_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT64_MAX     = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
  } draw_result_t;

  // one row of the directed table; known marks a hand-written expectation
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seed;
    logic [63:0] range_min;
    logic [63:0] range_max;
    logic        known;
    logic [63:0] value;
    logic        error;
  } draw_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // seed[31:0], range_min[95:32], range_max[159:96]
  logic [1:0]   s_axis_tuser = '0;   // op[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // value[63:0]
  logic [0:0]   m_axis_tuser;        // error[0]

  // generator words of the prediction
  logic [31:0] gen_a;
  logic [31:0] gen_b;
  logic [31:0] gen_c;
  logic [31:0] gen_d;

  draw_result_t expected_draws[$];
  int unsigned  fail_count = 0;
  draw_row_t    directed_rows [N_DIRECTED];

  jsf32_prng_bounded_draw_unit #(
    .WARMUP_ROUNDS(WARMUP_ROUNDS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // one generator round; returns the new d word
  function automatic logic [31:0] gen_advance();
    logic [31:0] e;
    e     = gen_a - {gen_b[4:0], gen_b[31:5]};
    gen_a = gen_b ^ {gen_c[14:0], gen_c[31:15]};
    gen_b = gen_c + gen_d;
    gen_c = gen_d + e;
    gen_d = e + gen_a;
    return gen_d;
  endfunction

  // expected response of one request, advancing the generator words
  function automatic draw_result_t predict_draw(input logic [1:0] op, input logic [31:0] seed,
                                                input logic [63:0] mn, input logic [63:0] mx);
    draw_result_t res;
    logic [31:0]  r;
    logic [31:0]  span32;
    logic [63:0]  span64;
    logic [63:0]  thresh;
    logic [63:0]  joined;
    res = '0;
    case (op)
      jsfbd_pkg::OP_RESEED: begin
        gen_a = jsfbd_pkg::SEED_CONST;
        gen_b = seed;
        gen_c = seed;
        gen_d = seed;
        repeat (WARMUP_ROUNDS) void'(gen_advance());
      end
      jsfbd_pkg::OP_DRAW32: begin
        if (mx[31:0] < mn[31:0]) begin
          res.error = 1'b1;
        end else begin
          r      = gen_advance();
          span32 = mx[31:0] - mn[31:0] + 32'd1;
          // zero span means the full 32-bit range: no reduction
          res.value = {32'd0, (span32 != 0) ? mn[31:0] + r % span32 : mn[31:0] + r};
        end
      end
      jsfbd_pkg::OP_DRAW64: begin
        if ($signed(mx) < $signed(mn)) begin
          res.error = 1'b1;
        end else begin
          span64 = mx - mn + 64'd1;
          thresh = (span64 != 0) ? (64'd0 - span64) % span64 : 64'd0;
          // reject joins below the bias threshold, high word first
          do begin
            joined[63:32] = gen_advance();
            joined[31:0]  = gen_advance();
          end while (joined < thresh);
          if (span64 != 0) joined = joined % span64;
          res.value = mn + joined;
        end
      end
      default: begin
        if (mx[31:0] == 0) begin
          res.error = 1'b1;
        end else begin
          r         = gen_advance();
          res.value = {63'd0, (r % mx[31:0]) == 0};
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random request, mostly well-formed ranges with some errors and extremes
  task automatic make_random_req(output logic [1:0] op, output logic [31:0] seed,
                                 output logic [63:0] mn, output logic [63:0] mx);
    int unsigned kind;
    int unsigned pick;
    logic [63:0] tmp;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    seed = $urandom();
    mn   = rand64();
    mx   = rand64();
    if (kind < 8) begin
      op = jsfbd_pkg::OP_RESEED;
    end else if (kind < 38) begin
      op = jsfbd_pkg::OP_DRAW32;
      if (pick < 7) begin
        mx[31:0] = mn[31:0] + $urandom_range(0, 100);
      end else if (pick == 7) begin
        mn[31:0] = 32'd0;
        mx[31:0] = 32'hffff_ffff;
      end else if (pick == 8) begin
        mx[31:0] = mn[31:0];
      end
      // one in twenty reversed, others put in order
      if ((pick == 19) ? (mx[31:0] > mn[31:0]) : (mx[31:0] < mn[31:0])) begin
        tmp[31:0] = mn[31:0];
        mn[31:0]  = mx[31:0];
        mx[31:0]  = tmp[31:0];
      end
    end else if (kind < 69) begin
      op = jsfbd_pkg::OP_DRAW64;
      if (pick < 6) begin
        mx = mn + $urandom_range(0, 200);
      end else if (pick < 9) begin
        mx = mn + {32'd0, $urandom()};
      end else if (pick < 13) begin
        case ($urandom_range(0, 3))
          0: mn = INT64_MIN;
          1: mn = '1;
          2: mn = '0;
          default: ;
        endcase
        case ($urandom_range(0, 2))
          0: mx = INT64_MAX;
          1: mx = '0;
          default: ;
        endcase
      end
      if ((pick == 19) ? ($signed(mx) > $signed(mn)) : ($signed(mx) < $signed(mn))) begin
        tmp = mn;
        mn  = mx;
        mx  = tmp;
      end
    end else begin
      op = jsfbd_pkg::OP_LUCKY;
      if (pick < 12) mx[31:0] = $urandom_range(1, 8);
      else if (pick == 19) mx[31:0] = 32'd0;
    end
  endtask

  // present one request and wait for it to be taken; the expectation is queued on accept
  task automatic send_req(input logic [1:0] op, input logic [31:0] seed,
                          input logic [63:0] mn, input logic [63:0] mx,
                          input logic known, input logic [63:0] value, input logic error);
    draw_result_t pred;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {mx, mn, seed};
    do @(posedge clk); while (!s_axis_tready);
    pred = predict_draw(op, seed, mn, mx);
    if (known) begin
      pred.value = value;
      pred.error = error;
    end
    expected_draws.push_back(pred);
  endtask

  // receiver readiness: a pattern that changes each time ready_tick wraps
  logic [5:0]  ready_tick = '0;
  logic [1:0]  ready_mode = '0;
  always @(negedge clk) begin
    ready_tick <= ready_tick + 6'd1;
    if (ready_tick == 0) ready_mode <= 2'($urandom_range(0, 3));
    case (ready_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (ready_tick[2:0] < 3'd5);
    endcase
  end

  // compare each taken response with the oldest expectation
  always @(posedge clk) begin : check_results
    draw_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected response: value %h error %b", m_axis_tdata, m_axis_tuser[0]);
        fail_count++;
      end else begin
        want = expected_draws.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("value: expected %h, actual %h", want.value, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.error) begin
          $error("error: expected %b, actual %b", want.error, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0]  op;
    logic [31:0] seed;
    logic [63:0] mn;
    logic [63:0] mx;
    int unsigned burst;
    int unsigned gap;

    directed_rows = '{
      // first draw after reset over the full range gives the seeding constant
      '{jsfbd_pkg::OP_DRAW32, 32'd0, 64'd0, 64'hffff_ffff, 1'b1, 64'hf1ea_5eed, 1'b0},
      // range errors leave the generator alone
      '{jsfbd_pkg::OP_DRAW32, 32'd0, 64'd5, 64'd4, 1'b1, 64'd0, 1'b1},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, 64'd0, '1, 1'b1, 64'd0, 1'b1},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, INT64_MAX, INT64_MIN, 1'b1, 64'd0, 1'b1},
      '{jsfbd_pkg::OP_LUCKY, 32'd0, 64'd0, 64'd0, 1'b1, 64'd0, 1'b1},
      // difficulty upper bits ignored, so still zero
      '{jsfbd_pkg::OP_LUCKY, 32'd0, 64'd0, 64'hffff_ffff_0000_0000, 1'b1, 64'd0, 1'b1},
      '{jsfbd_pkg::OP_RESEED, 32'd0, '1, '1, 1'b1, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW32, 32'hffff_ffff, 64'd7, 64'd7, 1'b1, 64'd7, 1'b0},
      '{jsfbd_pkg::OP_DRAW32, 32'd0, '1, 64'hffff_ffff, 1'b1, 64'hffff_ffff, 1'b0},
      '{jsfbd_pkg::OP_LUCKY, 32'd0, 64'd0, 64'd1, 1'b1, 64'd1, 1'b0},
      '{jsfbd_pkg::OP_LUCKY, 32'd0, 64'd0, 64'h8000_0000_0000_0003, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_LUCKY, 32'd0, 64'd0, 64'hffff_ffff, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, -64'sd5, -64'sd5, 1'b1, -64'sd5, 1'b0},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, INT64_MIN, INT64_MIN, 1'b1, INT64_MIN, 1'b0},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, INT64_MAX, INT64_MAX, 1'b1, INT64_MAX, 1'b0},
      // full 64-bit range: raw join
      '{jsfbd_pkg::OP_DRAW64, 32'd0, INT64_MIN, INT64_MAX, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, 64'd0, INT64_MAX, 1'b0, 64'd0, 1'b0},
      // span just over 2^63: about half the joins are rejected
      '{jsfbd_pkg::OP_DRAW64, 32'd0, '1, INT64_MAX, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, INT64_MIN, 64'd0, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_RESEED, 32'hffff_ffff, 64'd0, 64'd0, 1'b1, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW32, 32'd0, 64'd0, 64'd9, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW32, 32'd0, 64'h8000_0000, 64'hffff_fffe, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_DRAW32, 32'd0, 64'hffff_ffff, 64'd0, 1'b1, 64'd0, 1'b1},
      '{jsfbd_pkg::OP_DRAW64, 32'd0, -64'sd10, 64'sd10, 1'b0, 64'd0, 1'b0},
      '{jsfbd_pkg::OP_RESEED, 32'h1234_5678, 64'd0, 64'd0, 1'b1, 64'd0, 1'b0}
    };

    gen_a = jsfbd_pkg::SEED_CONST;
    gen_b = '0;
    gen_c = '0;
    gen_d = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed table, sent back to back
    foreach (directed_rows[i])
      send_req(directed_rows[i].op, directed_rows[i].seed, directed_rows[i].range_min,
               directed_rows[i].range_max, directed_rows[i].known, directed_rows[i].value,
               directed_rows[i].error);

    // random requests in bursts with gaps
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // hold off until the block has delivered everything
        @(negedge clk) s_axis_tvalid <= 1'b0;
        wait (expected_draws.size() == 0);
      end else if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        if (gap != 0) begin
          @(negedge clk) s_axis_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst = $urandom_range(1, 16);
      end
      make_random_req(op, seed, mn, mx);
      send_req(op, seed, mn, mx, 1'b0, 64'd0, 1'b0);
      if (burst != 0) burst--;
    end

    @(negedge clk) s_axis_tvalid <= 1'b0;
    wait (expected_draws.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_draws.size() == 0 && fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
